// File: rtl/frc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_pkg: shared types and constants of the fragment reassembly checker
// Holds the header and result beat layouts, the status codes, the header
// constants and the register map.
// ----------------------------------------------------------------------------
package frc_pkg;

  localparam logic [3:0] MARKER_VALUE = 4'hA;
  localparam logic [5:0] TYPE_WHOLE   = 6'h20;
  localparam logic [5:0] TYPE_LAST    = 6'h23;
  localparam logic [9:0] MAX_PAYLOAD  = 10'd1020;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BAD    = 3'd1;
  localparam logic [2:0] ST_DESYNC = 3'd2;
  localparam logic [2:0] ST_ORDER  = 3'd3;
  localparam logic [2:0] ST_SMALL  = 3'd4;

  // Register map: one 32-bit register per word, index taken from paddr[2].
  localparam int unsigned PADDR_W          = 3;
  localparam logic        REG_BUFFER_SIZE  = 1'b0;
  localparam logic [15:0] BUFFER_SIZE_RST  = 16'hFFFF;

  typedef struct packed {
    logic [3:0] marker;
    logic [5:0] msg_type;
    logic [5:0] seq;
    logic [5:0] frag_seq;
    logic [9:0] data_len;
  } frc_hdr_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] append_offset;
    logic [15:0] message_length;
    logic        message_done;
    logic [31:0] total_bytes;
  } frc_res_t;

endpackage

// File: rtl/frc_hdr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_hdr_if: header channel
// Valid/ready channel that carries one parsed packet header per beat.
// ----------------------------------------------------------------------------
interface frc_hdr_if;
  logic       valid;
  logic       ready;
  logic [3:0] marker;
  logic [5:0] msg_type;
  logic [5:0] seq;
  logic [5:0] frag_seq;
  logic [9:0] data_len;

  modport source (output valid, marker, msg_type, seq, frag_seq, data_len, input ready);
  modport sink   (input valid, marker, msg_type, seq, frag_seq, data_len, output ready);
endinterface

// File: rtl/frc_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_res_if: result channel
// Valid/ready channel that carries one check result per beat.
// ----------------------------------------------------------------------------
interface frc_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] append_offset;
  logic [15:0] message_length;
  logic        message_done;
  logic [31:0] total_bytes;

  modport source (output valid, status, append_offset, message_length, message_done,
                  total_bytes, input ready);
  modport sink   (input valid, status, append_offset, message_length, message_done,
                  total_bytes, output ready);
endinterface

// File: rtl/frc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_regs: configuration registers
// APB-style write and read access to the buffer size register.
// ----------------------------------------------------------------------------
module frc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [frc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [15:0]                  buffer_size
);
  import frc_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_BUFFER_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= BUFFER_SIZE_RST;
    end else if (wr_en) begin
      buffer_size <= pwdata[15:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BUFFER_SIZE: prdata = {16'd0, buffer_size};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/frc_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_check: header checks and message state
// Checks one header against the open message, forms the result and
// updates the message state on each accepted beat.
// ----------------------------------------------------------------------------
module frc_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  frc_pkg::frc_hdr_t hdr,
  input  logic [15:0]       buffer_size,
  output frc_pkg::frc_res_t res
);
  import frc_pkg::*;

  logic        in_message, in_message_next;
  logic [5:0]  held_seq, held_seq_next;
  logic [5:0]  held_frag, held_frag_next;
  logic [15:0] bytes_so_far, bytes_so_far_next;
  logic [31:0] total_read, total_read_next;

  logic        bad;
  logic [6:0]  frag_expect;
  logic [16:0] sum;
  logic [2:0]  status;
  logic        is_end;

  always_comb begin
    bad = (hdr.marker != MARKER_VALUE) || (hdr.msg_type < TYPE_WHOLE) ||
          (hdr.msg_type > TYPE_LAST) || (hdr.data_len == 10'd0) ||
          (hdr.data_len > MAX_PAYLOAD);
    frag_expect = {1'b0, held_frag} + 7'd1;
    sum         = {1'b0, bytes_so_far} + {7'd0, hdr.data_len};
    is_end      = (hdr.msg_type == TYPE_WHOLE) || (hdr.msg_type == TYPE_LAST);

    if (bad) begin
      status = ST_BAD;
    end else if (in_message && (hdr.seq != held_seq)) begin
      status = ST_DESYNC;
    end else if (in_message && ({1'b0, hdr.frag_seq} != frag_expect)) begin
      status = ST_ORDER;
    end else if (sum > {1'b0, buffer_size}) begin
      status = ST_SMALL;
    end else begin
      status = ST_OK;
    end

    in_message_next   = 1'b0;
    held_seq_next     = 6'd0;
    held_frag_next    = 6'd0;
    bytes_so_far_next = 16'd0;
    total_read_next   = total_read;

    res.status         = status;
    res.append_offset  = 16'd0;
    res.message_length = bytes_so_far;
    res.message_done   = 1'b1;

    if (status == ST_OK) begin
      res.append_offset  = bytes_so_far;
      res.message_length = sum[15:0];
      if (is_end) begin
        total_read_next = total_read + {16'd0, sum[15:0]};
      end else begin
        res.message_done  = 1'b0;
        in_message_next   = 1'b1;
        held_seq_next     = hdr.seq;
        held_frag_next    = hdr.frag_seq;
        bytes_so_far_next = sum[15:0];
      end
    end
    res.total_bytes = total_read_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message   <= 1'b0;
      held_seq     <= 6'd0;
      held_frag    <= 6'd0;
      bytes_so_far <= 16'd0;
      total_read   <= 32'd0;
    end else if (accept) begin
      in_message   <= in_message_next;
      held_seq     <= held_seq_next;
      held_frag    <= held_frag_next;
      bytes_so_far <= bytes_so_far_next;
      total_read   <= total_read_next;
    end
  end

endmodule

// File: rtl/frc_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_out_buf: result output register with skid stage
// Two-entry buffer that registers results and keeps ready registered.
// ----------------------------------------------------------------------------
module frc_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  frc_pkg::frc_res_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output frc_pkg::frc_res_t out_data
);
  import frc_pkg::*;

  logic     main_valid;
  frc_res_t main_data;
  logic     skid_valid;
  frc_res_t skid_data;
  logic     push;

  assign in_ready  = !skid_valid;
  assign push      = in_valid && in_ready;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || out_ready) begin
      main_data <= skid_valid ? skid_data : in_data;
    end else if (push) begin
      skid_data <= in_data;
    end
  end

endmodule

// File: rtl/fragment_reassembly_checker.sv
`timescale 1ns / 1ps
// Output: the result of an accepted header beat is registered in the output
// buffer (main register, or skid register while the result channel stalls).
// Throughput: one header per cycle while the output buffer has room; checks
// and the state update are done in the same cycle the header is accepted.
// Reset: synchronous rst clears the message state and byte total and sets
// buffer_size to 65535.
// ----------------------------------------------------------------------------
// fragment_reassembly_checker: message fragment reassembly checker
// Checks parsed packet headers in order and reports status, append offset,
// message length and a running total of completed message bytes.
// ----------------------------------------------------------------------------
module fragment_reassembly_checker (
  input  logic                         clk,
  input  logic                         rst,
  frc_hdr_if.sink                      hdr,
  frc_res_if.source                    res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [frc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import frc_pkg::*;

  logic [15:0] buffer_size;
  frc_hdr_t    hdr_beat;
  frc_res_t    chk_res;
  frc_res_t    out_res;
  logic        hdr_accept;

  // Collect the header channel fields into one beat.
  assign hdr_beat.marker   = hdr.marker;
  assign hdr_beat.msg_type = hdr.msg_type;
  assign hdr_beat.seq      = hdr.seq;
  assign hdr_beat.frag_seq = hdr.frag_seq;
  assign hdr_beat.data_len = hdr.data_len;

  // A header beat is taken whenever the output buffer has room. The state
  // advances at the same edge, so the next header is checked against it.
  assign hdr_accept = hdr.valid && hdr.ready;

  frc_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .buffer_size (buffer_size)
  );

  frc_check u_check (
    .clk         (clk),
    .rst         (rst),
    .accept      (hdr_accept),
    .hdr         (hdr_beat),
    .buffer_size (buffer_size),
    .res         (chk_res)
  );

  // The output register and skid stage keep the result side apart from the
  // header side: ready toward the header source is a flop.
  frc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hdr.valid),
    .in_ready  (hdr.ready),
    .in_data   (chk_res),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (out_res)
  );

  assign res.status         = out_res.status;
  assign res.append_offset  = out_res.append_offset;
  assign res.message_length = out_res.message_length;
  assign res.message_done   = out_res.message_done;
  assign res.total_bytes    = out_res.total_bytes;

endmodule
